// ===== rtl/esa_pkg.sv =====
// ----------------------------------------------------------------------------
// esa_pkg
// Shared constants, status codes and types for the exact binary64
// superaccumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package esa_pkg;

  localparam int LIMB_COUNT    = 20;
  localparam int LIMB_W        = 64;
  localparam int FRACTION_BITS = 1074;
  localparam int LIMB_IDX_W    = $clog2(LIMB_COUNT);

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NONFINITE    = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE    = 3'd2;
  localparam logic [2:0] ST_ACC_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_RANGE        = 3'd4;

  localparam logic [19:0] SCALE_FACTOR = 20'd1000000;

  // cell control, common to every cell of the row in any given cycle
  typedef struct packed {
    logic shift;    // row shifts one limb toward the low end
    logic sub;      // subtract instead of add
    logic swap;     // operand is larger: compute operand minus accumulator
    logic clear;    // zero every limb
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/esa_if.sv =====
// ----------------------------------------------------------------------------
// esa_in_if / esa_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface esa_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample_bits;
  logic        last_of_set;
  modport source (output valid, output sample_bits, output last_of_set, input ready);
  modport sink   (input valid, input sample_bits, input last_of_set, output ready);
endinterface

interface esa_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] rounded_sum;
  logic [2:0]         status;
  modport source (output valid, output rounded_sum, output status, input ready);
  modport sink   (input valid, input rounded_sum, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/esa_cell.sv =====
// ----------------------------------------------------------------------------
// esa_cell
// One 64-bit limb of the accumulator. The row rotates through the cells;
// the cell at the low end feeds the adder, and every cell holds or passes limbs along.
// ----------------------------------------------------------------------------
`default_nettype none

module esa_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          shift,
  input  wire logic                          clear,
  input  wire logic [esa_pkg::LIMB_W-1:0]    din,
  output logic      [esa_pkg::LIMB_W-1:0]    dout
);

  logic [esa_pkg::LIMB_W-1:0] limb;

  // hold or take the neighbor's limb
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      limb <= '0;
    end else if (shift) begin
      limb <= din;
    end
  end

  assign dout = limb;

endmodule

`default_nettype wire

// ===== rtl/esa_alu.sv =====
// ----------------------------------------------------------------------------
// esa_alu
// One-limb add/subtract with carry, feeding the high end of the row.
// ----------------------------------------------------------------------------
`default_nettype none

module esa_alu (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire esa_pkg::cell_ctrl_t           ctrl,
  input  wire logic                          first,
  input  wire logic [esa_pkg::LIMB_W-1:0]    acc,
  input  wire logic [esa_pkg::LIMB_W-1:0]    opnd,
  output logic      [esa_pkg::LIMB_W-1:0]    sum,
  output logic                               carry_out
);

  logic                      carry;
  logic [esa_pkg::LIMB_W:0]  wide;
  logic                      cin;

  // carry/borrow starts fresh on the first limb
  assign cin = first ? 1'b0 : carry;

  always_comb begin
    if (!ctrl.sub) begin
      wide = {1'b0, acc} + {1'b0, opnd} + {{esa_pkg::LIMB_W{1'b0}}, cin};
    end else if (ctrl.swap) begin
      wide = {1'b0, opnd} - {1'b0, acc} - {{esa_pkg::LIMB_W{1'b0}}, cin};
    end else begin
      wide = {1'b0, acc} - {1'b0, opnd} - {{esa_pkg::LIMB_W{1'b0}}, cin};
    end
  end

  assign sum       = wide[esa_pkg::LIMB_W-1:0];
  assign carry_out = wide[esa_pkg::LIMB_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      carry <= 1'b0;
    end else if (ctrl.shift) begin
      carry <= wide[esa_pkg::LIMB_W];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/exact_binary64_superaccumulator_top.sv =====
// ----------------------------------------------------------------------------
// exact_binary64_superaccumulator_top
// Exact sum of binary64 samples scaled by 1e6, rounded to int64 per set.
// ----------------------------------------------------------------------------
// A sample is taken while the block is idle. A finite nonzero sample of the
// running sum's sign then passes the 1e6 multiply, placement and range check
// states and the add pass, one limb a cycle through the shared limb adder,
// and the next sample is taken only once the block is idle again. A sample
// of the other sign first takes a compare pass over all twenty limbs. A zero
// ends after the range check; a NaN or infinity, or a sample that arrives
// while an error is held, goes no further than the idle state. On the last
// sample of a set a rounding pass follows unless an error is held, then the
// result is offered until it is taken, and the limbs, sign and error status
// clear with that transaction. The accumulator is a rotating row of twenty
// 64-bit limb cells; errors are sticky until the result of the set is taken.
`default_nettype none

module exact_binary64_superaccumulator_top (
  input wire logic  clk,
  input wire logic  rst,
  esa_in_if.sink    in_ch,
  esa_out_if.source out_ch
);

  localparam int N  = esa_pkg::LIMB_COUNT;
  localparam int W  = esa_pkg::LIMB_W;
  localparam int IW = esa_pkg::LIMB_IDX_W;

  // limb and bit where the integer part of the sum starts
  localparam int QLIMB = esa_pkg::FRACTION_BITS / W;
  localparam int QOFF  = esa_pkg::FRACTION_BITS % W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_ROUND = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]     state;
  logic [IW-1:0]  cnt;
  logic           last;
  logic           acc_neg;
  logic [2:0]     sticky;
  logic [1:0]     cmp;          // 0 equal, 1 acc bigger, 2 operand bigger
  logic           res_zero;
  logic           op_neg;
  logic           nonzero;
  logic [52:0]    sig;
  logic [10:0]    shift_amt;
  logic [72:0]    prod;         // sig * 1e6 needs 73 bits
  logic [3*W-1:0] opw;          // product aligned within its low limb
  logic [4:0]     lsel;         // limb that holds the low word of opw
  logic [62:0]    q;
  logic           half_bit;
  logic           below;
  logic           range_err;

  // decode
  logic [10:0] raw_exp;
  logic [51:0] frac;
  logic [10:0] sh_calc;

  assign raw_exp = in_ch.sample_bits[62:52];
  assign frac    = in_ch.sample_bits[51:0];
  // shift = exp - 1023 - 52 + 1074 = exp - 1, subnormals sit at zero
  assign sh_calc = (raw_exp == 11'd0) ? 11'd0 : (raw_exp - 11'd1);

  // operand limb at the walked position
  logic [W-1:0] opnd;
  always_comb begin
    opnd = '0;
    if (6'(cnt) == 6'(lsel)) begin
      opnd = opw[W-1:0];
    end else if (6'(cnt) == 6'(lsel) + 6'd1) begin
      opnd = opw[2*W-1:W];
    end else if (6'(cnt) == 6'(lsel) + 6'd2) begin
      opnd = opw[3*W-1:2*W];
    end
  end

  // too large: a nonzero word of the operand lands beyond the top limb
  logic too_large;
  always_comb begin
    too_large = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if ((6'(lsel) + 6'(j) >= 6'(N)) && (opw[j*W +: W] != '0)) too_large = 1'b1;
    end
  end

  // limb row: cell 0 is the low end and feeds the adder
  logic [W-1:0]        limb_q [N];
  logic [W-1:0]        alu_sum;
  logic                alu_cout;
  logic [W-1:0]        feed;
  esa_pkg::cell_ctrl_t ctrl;

  always_comb begin
    ctrl       = '0;
    ctrl.sub   = (acc_neg != op_neg);
    ctrl.swap  = (cmp == 2'd2);
    ctrl.shift = (state == S_CMP) || (state == S_ADD) || (state == S_ROUND);
    ctrl.clear = (state == S_OUT) && out_ch.ready;
  end

  // the add pass writes sums back, the other passes just rotate
  assign feed = (state == S_ADD) ? alu_sum : limb_q[0];

  for (genvar g = 0; g < N; g++) begin : g_row
    logic [W-1:0] din;
    if (g == N - 1) begin : g_top
      assign din = feed;
    end else begin : g_mid
      assign din = limb_q[g+1];
    end
    esa_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctrl.shift),
      .clear (ctrl.clear),
      .din   (din),
      .dout  (limb_q[g])
    );
  end

  esa_alu u_alu (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .first     (cnt == '0),
    .acc       (limb_q[0]),
    .opnd      (opnd),
    .sum       (alu_sum),
    .carry_out (alu_cout)
  );

  // zero tracking and sign of the sum after the add pass
  logic sum_zero;
  logic new_neg;
  assign sum_zero = ((cnt == '0) || res_zero) && (alu_sum == '0);
  assign new_neg  = sum_zero ? 1'b0 : ((ctrl.sub && !ctrl.swap) ? acc_neg : op_neg);

  // rounding pass: limb cnt sits at the low end of the row
  logic [W-1:0] lo;
  logic         below_part;
  logic         range_part;
  assign lo = limb_q[0];

  always_comb begin
    below_part = 1'b0;
    range_part = 1'b0;
    if (cnt < IW'(QLIMB)) begin
      below_part = |lo;
    end else if (cnt == IW'(QLIMB)) begin
      below_part = |lo[QOFF-2:0];
    end else if (cnt == IW'(QLIMB + 1)) begin
      range_part = |lo[W-1:QOFF-1];
    end else begin
      range_part = |lo;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      last     <= 1'b0;
      acc_neg  <= 1'b0;
      sticky   <= esa_pkg::ST_OK;
      cmp      <= 2'd0;
      res_zero <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            last <= in_ch.last_of_set;
            cnt  <= '0;
            if (sticky != esa_pkg::ST_OK) begin
              state <= in_ch.last_of_set ? S_OUT : S_IDLE;
            end else if (raw_exp == 11'h7ff) begin
              sticky <= esa_pkg::ST_NONFINITE;
              state  <= in_ch.last_of_set ? S_OUT : S_IDLE;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_PLACE;
        end
        S_PLACE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          cmp <= 2'd0;
          cnt <= '0;
          if (too_large) begin
            sticky <= esa_pkg::ST_TOO_LARGE;
            state  <= last ? S_OUT : S_IDLE;
          end else if (!nonzero) begin
            state <= last ? S_ROUND : S_IDLE;
          end else if (acc_neg != op_neg) begin
            state <= S_CMP;
          end else begin
            state <= S_ADD;
          end
        end
        S_CMP: begin
          // walking up, the highest differing limb decides
          if (limb_q[0] != opnd) cmp <= (limb_q[0] > opnd) ? 2'd1 : 2'd2;
          if (cnt == IW'(N - 1)) begin
            cnt   <= '0;
            state <= S_ADD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ADD: begin
          res_zero <= sum_zero;
          if (cnt == IW'(N - 1)) begin
            cnt <= '0;
            if (!ctrl.sub && alu_cout) begin
              sticky <= esa_pkg::ST_ACC_OVERFLOW;
              state  <= last ? S_OUT : S_IDLE;
            end else begin
              acc_neg <= new_neg;
              state   <= last ? S_ROUND : S_IDLE;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROUND: begin
          if (cnt == IW'(N - 1)) begin
            cnt   <= '0;
            state <= S_OUT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state   <= S_IDLE;
            sticky  <= esa_pkg::ST_OK;
            acc_neg <= 1'b0;
            last    <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // operand preparation and rounding data
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      op_neg    <= in_ch.sample_bits[63];
      nonzero   <= (raw_exp != 11'd0) || (frac != '0);
      sig       <= (raw_exp == 11'd0) ? {1'b0, frac} : {1'b1, frac};
      shift_amt <= sh_calc;
    end
    if (state == S_MUL) begin
      prod <= 73'(sig) * 73'(esa_pkg::SCALE_FACTOR);
    end
    if (state == S_PLACE) begin
      opw  <= 192'(prod) << shift_amt[5:0];
      lsel <= shift_amt[10:6];
    end
    if (state == S_ROUND) begin
      if (cnt == IW'(QLIMB)) begin
        q[W-QOFF-1:0] <= lo[W-1:QOFF];
        half_bit      <= lo[QOFF-1];
      end
      if (cnt == IW'(QLIMB + 1)) begin
        q[62:W-QOFF] <= lo[QOFF-2:0];
      end
      below     <= ((cnt == '0) ? 1'b0 : below) | below_part;
      range_err <= ((cnt == '0) ? 1'b0 : range_err) | range_part;
    end
  end

  // result formation
  logic [W-1:0] res_sum;
  logic [2:0]   res_st;
  logic [63:0]  q_rnd;
  assign q_rnd = {1'b0, q} + {63'd0, half_bit && (below || q[0])};

  always_comb begin
    res_st  = sticky;
    res_sum = '0;
    if (sticky == esa_pkg::ST_OK) begin
      if (range_err) res_st = esa_pkg::ST_RANGE;
      else if (acc_neg) begin
        if (q_rnd > 64'h8000_0000_0000_0000) res_st = esa_pkg::ST_RANGE;
        else res_sum = 64'd0 - q_rnd;
      end else begin
        if (q_rnd[63]) res_st = esa_pkg::ST_RANGE;
        else res_sum = q_rnd;
      end
    end
    if (res_st != esa_pkg::ST_OK) res_sum = '0;
  end

  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = (state == S_OUT);
  assign out_ch.rounded_sum = res_sum;
  assign out_ch.status      = res_st;

  // assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("ready while result pending");
  a_clear_sign: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready) |=> !acc_neg) else $error("sign not cleared");
  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.status != esa_pkg::ST_OK) |-> out_ch.rounded_sum == '0)
    else $error("nonzero sum on error");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.rounded_sum)
      && $stable(out_ch.status)) else $error("result changed while waiting");

endmodule

`default_nettype wire

// ===== verif/exact_binary64_superaccumulator_top_test.sv =====
// ----------------------------------------------------------------------------
// exact_binary64_superaccumulator_top_test
// Drives binary64 samples grouped in sets into the superaccumulator and checks
// every rounded sum and status against a 1280-bit sign-magnitude predictor.
// Both channels idle and stall in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
`default_nettype none

class rounded_sum_scoreboard;
  localparam int MAG_W = esa_pkg::LIMB_COUNT * esa_pkg::LIMB_W;

  bit [MAG_W-1:0] acc_mag;
  bit             acc_neg;
  bit [2:0]       held_status;
  bit [63:0]      sum_q[$];
  bit [2:0]       status_q[$];
  int             mismatches;
  int             sets_done;
  int             set_errors;

  function void clear_sum();
    acc_mag     = '0;
    acc_neg     = 1'b0;
    held_status = esa_pkg::ST_OK;
  endfunction

  // decode, scale by 1e6 and place at the fixed point
  function bit [2:0] scale_sample(input bit [63:0] bits, output bit [MAG_W-1:0] mag);
    bit [10:0]   expo;
    bit [52:0]   sig;
    bit [127:0]  prod;
    bit [2299:0] wide;
    int          pos;
    mag  = '0;
    expo = bits[62:52];
    if (expo == 11'h7ff) return esa_pkg::ST_NONFINITE;
    if (expo == 0 && bits[51:0] == 0) return esa_pkg::ST_OK;
    sig  = (expo == 0) ? {1'b0, bits[51:0]} : {1'b1, bits[51:0]};
    pos  = (expo == 0) ? 0 : int'(expo) - 1023 - 52 + esa_pkg::FRACTION_BITS;
    prod = 128'(sig) * 128'(esa_pkg::SCALE_FACTOR);
    wide = 2300'(prod) << pos;
    if (|wide[2299:MAG_W]) return esa_pkg::ST_TOO_LARGE;
    mag = wide[MAG_W-1:0];
    return esa_pkg::ST_OK;
  endfunction

  // signed add into the sign-magnitude accumulator
  function bit [2:0] accumulate_value(input bit [MAG_W-1:0] mag, input bit neg);
    bit [MAG_W:0] total;
    bit           res_neg;
    if (mag == 0) return esa_pkg::ST_OK;
    if (neg == acc_neg) begin
      total = {1'b0, acc_mag} + {1'b0, mag};
      if (total[MAG_W]) return esa_pkg::ST_ACC_OVERFLOW;
      res_neg = neg;
    end else if (acc_mag >= mag) begin
      total   = {1'b0, acc_mag - mag};
      res_neg = acc_neg;
    end else begin
      total   = {1'b0, mag - acc_mag};
      res_neg = neg;
    end
    acc_mag = total[MAG_W-1:0];
    acc_neg = (acc_mag == 0) ? 1'b0 : res_neg;
    return esa_pkg::ST_OK;
  endfunction

  // round half to even into a signed 64-bit value
  function bit [2:0] round_even(output bit [63:0] val);
    bit [63:0] q;
    val = '0;
    if (|acc_mag[MAG_W-1:esa_pkg::FRACTION_BITS+63]) return esa_pkg::ST_RANGE;
    q = {1'b0, acc_mag[esa_pkg::FRACTION_BITS+62:esa_pkg::FRACTION_BITS]};
    if (acc_mag[esa_pkg::FRACTION_BITS-1] &&
        (|acc_mag[esa_pkg::FRACTION_BITS-2:0] || q[0])) q = q + 1;
    if (acc_neg) begin
      if (q > 64'h8000_0000_0000_0000) return esa_pkg::ST_RANGE;
      val = -q;
    end else begin
      if (q >= 64'h8000_0000_0000_0000) return esa_pkg::ST_RANGE;
      val = q;
    end
    return esa_pkg::ST_OK;
  endfunction

  function void note_sample(input bit [63:0] bits, input bit last);
    bit [MAG_W-1:0] mag;
    bit [2:0]       st;
    bit [63:0]      val;
    if (held_status == esa_pkg::ST_OK) begin
      st = scale_sample(bits, mag);
      if (st == esa_pkg::ST_OK) st = accumulate_value(mag, bits[63]);
      held_status = st;
    end
    if (last) begin
      st = held_status;
      if (st == esa_pkg::ST_OK) st = round_even(val);
      if (st != esa_pkg::ST_OK) begin
        val = '0;
        set_errors++;
      end
      sum_q    = {sum_q, val};
      status_q = {status_q, st};
      sets_done++;
      clear_sum();
    end
  endfunction

  task report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task check_result(input bit [63:0] sum, input bit [2:0] st);
    bit [63:0] exp_sum;
    bit [2:0]  exp_st;
    if (sum_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result sum=%0d status=%0d", $signed(sum), st));
      return;
    end
    exp_sum = sum_q.pop_front();
    exp_st  = status_q.pop_front();
    if (st != exp_st)
      report_mismatch($sformatf("status %0d, expected %0d", st, exp_st));
    if (sum != exp_sum)
      report_mismatch($sformatf("rounded_sum %0d, expected %0d", $signed(sum), $signed(exp_sum)));
  endtask
endclass

module exact_binary64_superaccumulator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 750;
  localparam int CALM_ITEMS   = 100;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;
  int   idle_cycles = 0;
  int   items_sent = 0;

  esa_in_if  in_ch();
  esa_out_if out_ch();

  rounded_sum_scoreboard sb = new();

  exact_binary64_superaccumulator_top DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.sample_bits = '0;
    in_ch.last_of_set = 1'b0;
    out_ch.ready      = 1'b0;
  end

  // transaction monitor and stall watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.sample_bits, in_ch.last_of_set);
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.rounded_sum, out_ch.status);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("exact_binary64_superaccumulator_top test failed");
        $finish;
      end
    end
  end

  // result side back-pressure in bursts
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (calm || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(0, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 6)) @(posedge clk);
      end
    end
  end

  // present one sample and hold it until taken
  task send_sample(input bit [63:0] bits, input bit last);
    in_ch.valid       <= 1'b1;
    in_ch.sample_bits <= bits;
    in_ch.last_of_set <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  function automatic bit [63:0] make_double(input bit sgn, input int expo, input bit [51:0] frac);
    return {sgn, 11'(expo), frac};
  endfunction

  // random sample, mostly in the range that rounds to a valid int64
  function automatic bit [63:0] random_sample();
    int        pick;
    bit        sgn;
    bit [51:0] frac;
    pick = $urandom_range(0, 99);
    sgn  = 1'($urandom_range(0, 1));
    frac = 52'({$urandom(), $urandom()});
    if (pick < 62) return make_double(sgn, $urandom_range(1023 - 40, 1023 + 38), frac);
    if (pick < 70) return make_double(sgn, $urandom_range(1023 - 27, 1023 - 1),
                                      {frac[51:40], 40'd0});
    if (pick < 76) return make_double(sgn, $urandom_range(0, 200), frac);
    if (pick < 80) return make_double(sgn, 0, '0);
    if (pick < 84) return {$urandom(), $urandom()};
    if (pick < 86) return make_double(sgn, 2047, frac);
    if (pick < 89) return make_double(sgn, $urandom_range(1023 + 180, 1023 + 188), frac);
    if (pick < 94) return make_double(sgn, $urandom_range(1023 + 39, 1023 + 44), frac);
    return make_double(sgn, $urandom_range(1023 - 80, 1023 - 30), frac);
  endfunction

  initial begin
    bit [63:0] bits;
    int        set_len;
    int        n;
    sb.clear_sum();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zeros, unity, ties, subnormals, non-finite, too-large and out-of-range sums
    send_sample(64'h0000_0000_0000_0000, 1'b1);
    send_sample(64'h8000_0000_0000_0000, 1'b1);
    send_sample(64'h3ff0_0000_0000_0000, 1'b1);
    send_sample(64'hbff8_0000_0000_0000, 1'b1);
    send_sample(64'h3f80_0000_0000_0000, 1'b1);
    send_sample(64'h3f98_0000_0000_0000, 1'b1);
    send_sample(64'h0000_0000_0000_0001, 1'b1);
    send_sample(64'h800f_ffff_ffff_ffff, 1'b1);
    send_sample(64'h3ff0_0000_0000_0000, 1'b0);
    send_sample(64'hbff0_0000_0000_0000, 1'b1);
    send_sample(64'h7ff8_0000_0000_0001, 1'b0);
    send_sample(64'h3ff0_0000_0000_0000, 1'b1);
    send_sample(64'hfff0_0000_0000_0000, 1'b1);
    send_sample(64'h7fef_ffff_ffff_ffff, 1'b1);
    send_sample(64'h4b7f_ffff_ffff_ffff, 1'b0);
    send_sample(64'h4b7f_ffff_ffff_ffff, 1'b1);
    send_sample(64'h42b0_0000_0000_0000, 1'b1);
    send_sample(64'hc2a0_0000_0000_0000, 1'b1);
    send_sample(64'h42a0_0000_0000_0000, 1'b1);
    send_sample(64'hc2a0_c6f7_a0b5_ed8d, 1'b1);
    send_sample(64'h7fff_ffff_ffff_ffff, 1'b1);

    // random sets of one to six samples
    n = 0;
    while (n < RANDOM_ITEMS) begin
      set_len = $urandom_range(1, 6);
      for (int i = 0; i < set_len; i++) begin
        if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
        bits = random_sample();
        send_sample(bits, i == set_len - 1);
        n++;
      end
    end
    in_ch.valid <= 1'b0;

    // drain, then allow for trailing activity
    while (sb.sum_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.sum_q.size() != 0) sb.report_mismatch("results still outstanding");

    $display("covered %0d samples in %0d sets, %0d of them ending with an error status",
             items_sent, sb.sets_done, sb.set_errors);
    if (sb.mismatches == 0) begin
      $display("exact_binary64_superaccumulator_top test passed");
    end else begin
      $display("exact_binary64_superaccumulator_top test failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
